FILE: hw/rtl/eers_pkg.sv
// Shared types, constants and CRC helpers for the record ring selector.
package eers_pkg;

  localparam int STORE_BYTES_DEF = 1024;
  localparam int ADDR_W          = 10;

  localparam logic [7:0]  RECORD_BYTES_RST = 8'd32;
  localparam logic [6:0]  SLOT_COUNT_RST   = 7'd16;
  localparam logic [7:0]  RECORD_BYTES_MIN = 8'd8;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [15:0] ALL_ONES         = 16'hFFFF;
  localparam logic [15:0] VER_LOW_BAND     = 16'd16384;
  localparam logic [15:0] VER_HIGH_BAND    = 16'd49152;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SCAN  = 2'd1,
    OP_SAVE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [1:0] CFG_RECORD_BYTES = 2'd0;
  localparam logic [1:0] CFG_SLOT_COUNT   = 2'd1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       pass_start;
    logic [5:0] slot_index;
    logic       copy_half;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        data_out;
    logic [ADDR_W-1:0] primary_addr;
    logic [ADDR_W-1:0] mirror_addr;
    logic              status;
    logic              record_end;
    logic              found;
    logic [15:0]       best_slot;
    logic              best_copy;
    logic [15:0]       best_version;
  } out_word_t;

  // reflected CRC-16, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // wrap-aware version compare
  function automatic logic is_newer(input logic [15:0] v, input logic [15:0] c,
                                    input logic found);
    logic res;
    if (!found) begin
      res = 1'b1;
    end else if (v < VER_LOW_BAND && c >= VER_HIGH_BAND) begin
      res = 1'b1;
    end else begin
      res = (v > c) && !(v >= VER_HIGH_BAND && c < VER_LOW_BAND);
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/eers_in_if.sv
// Input channel: valid/ready with one record byte word.
interface eers_in_if import eers_pkg::*;;
  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

FILE: hw/rtl/eers_out_if.sv
// Result channel: valid/ready with one result word.
interface eers_out_if import eers_pkg::*;;
  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

FILE: hw/rtl/eers_cfg_if.sv
// Configuration write channel: register index and data.
interface eers_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/eeprom_record_ring_selector.sv
// Record ring selector for a mirrored nonvolatile store: CRC check, best pick, save addressing.
//
// Usage:
//   in_if   : one word per record byte (op clear / scan / save, byte, pass start,
//             slot and mirror half of the scanned record).
//   out_if  : one result word per input word: save byte with version and CRC put in,
//             primary and mirror write addresses, status, record end and best record.
//   cfg_if  : register writes (0 record_bytes, 1 slot_count), always ready; write
//             only while the block is idle.
//   An accepted input word is held in the input register and its result in the
//   result register. One word is taken every cycle while the receiver keeps up;
//   the CRC byte update and the slot-times-length address multiply sit between them.
//   A full result register with a stalled receiver holds its word; the input
//   register still takes one more word, then in_if.ready drops until the
//   result is taken.
//   Reset: record_bytes 32, slot_count 16, slot and version all ones, nothing
//   loaded, CRC restarted, both registers empty.
module eeprom_record_ring_selector
  import eers_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  eers_in_if.sink       in_if,
  eers_out_if.source    out_if,
  eers_cfg_if.sink      cfg_if
);

  localparam logic [ADDR_W-1:0] MIRROR_OFFSET = ADDR_W'((STORE_BYTES / 2) % (1 << ADDR_W));

  // configuration
  logic [7:0] record_bytes_r;
  logic [6:0] slot_count_r;

  // input and result registers
  logic      in_valid_r;
  in_word_t  in_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      in_fire;
  logic      advance;

  // record state
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  vlo_r, vlo_nxt;
  logic [7:0]  vhi_r, vhi_nxt;
  logic [7:0]  clo_r, clo_nxt;
  logic [15:0] slot_r, slot_nxt;
  logic [15:0] ver_r, ver_nxt;
  logic        loaded_r, loaded_nxt;
  logic        found_r, found_nxt;
  logic        half_r, half_nxt;
  logic        refused_r, refused_nxt;

  // working values
  logic [7:0]        len;
  logic [7:0]        cur_pos;
  logic [15:0]       cur_crc;
  logic [15:0]       slot_inc;
  logic [7:0]        save_byte;
  logic [17:0]       prod;
  logic [ADDR_W-1:0] base;
  out_word_t         res;

  assign cfg_if.ready = 1'b1;
  assign advance      = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || advance;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.word  = out_word_r;

  assign len      = (record_bytes_r < RECORD_BYTES_MIN) ? RECORD_BYTES_MIN : record_bytes_r;
  assign slot_inc = slot_r + 16'd1;
  assign prod     = 18'(slot_nxt[ADDR_W-1:0]) * 18'(len);
  assign base     = prod[ADDR_W-1:0] + ADDR_W'(cur_pos);

  always_comb begin
    crc_nxt     = crc_r;
    pos_nxt     = pos_r;
    vlo_nxt     = vlo_r;
    vhi_nxt     = vhi_r;
    clo_nxt     = clo_r;
    slot_nxt    = slot_r;
    ver_nxt     = ver_r;
    loaded_nxt  = loaded_r;
    found_nxt   = found_r;
    half_nxt    = half_r;
    refused_nxt = refused_r;
    cur_pos     = pos_r;
    cur_crc     = crc_r;
    save_byte   = in_word_r.data_byte;
    res         = '0;

    case (op_t'(in_word_r.op))
      OP_CLEAR: begin
        slot_nxt   = ALL_ONES;
        ver_nxt    = ALL_ONES;
        loaded_nxt = 1'b1;
      end
      OP_SCAN: begin
        loaded_nxt = 1'b1;
        if (in_word_r.pass_start) begin
          found_nxt = 1'b0;
          cur_pos   = '0;
          cur_crc   = CRC_INIT;
        end
        if (cur_pos >= len - 8'd1) begin
          if ({in_word_r.data_byte, clo_r} == ~cur_crc &&
              is_newer({vhi_r, vlo_r}, ver_r, found_nxt)) begin
            slot_nxt  = {10'd0, in_word_r.slot_index};
            ver_nxt   = {vhi_r, vlo_r};
            half_nxt  = in_word_r.copy_half;
            found_nxt = 1'b1;
          end
          res.record_end = 1'b1;
          pos_nxt        = '0;
          crc_nxt        = CRC_INIT;
        end else begin
          if (cur_pos == len - 8'd4) begin
            vlo_nxt = in_word_r.data_byte;
          end else if (cur_pos == len - 8'd3) begin
            vhi_nxt = in_word_r.data_byte;
          end
          if (cur_pos == len - 8'd2) begin
            clo_nxt = in_word_r.data_byte;
            crc_nxt = cur_crc;
          end else begin
            crc_nxt = crc_byte(cur_crc, in_word_r.data_byte);
          end
          pos_nxt = cur_pos + 8'd1;
        end
      end
      OP_SAVE: begin
        if (in_word_r.pass_start) begin
          if (!loaded_r) begin
            refused_nxt = 1'b1;
          end else begin
            refused_nxt = 1'b0;
            slot_nxt    = (slot_inc >= {9'd0, slot_count_r}) ? 16'd0 : slot_inc;
            ver_nxt     = ver_r + 16'd1;
            cur_pos     = '0;
            cur_crc     = CRC_INIT;
          end
        end
        if (refused_nxt || !loaded_r) begin
          res.status = 1'b1;
        end else begin
          if (cur_pos >= len - 8'd1) begin
            save_byte      = ~cur_crc[15:8];
            res.record_end = 1'b1;
            pos_nxt        = '0;
            crc_nxt        = CRC_INIT;
          end else begin
            if (cur_pos == len - 8'd2) begin
              save_byte = ~cur_crc[7:0];
              crc_nxt   = cur_crc;
            end else begin
              if (cur_pos == len - 8'd4) begin
                save_byte = ver_nxt[7:0];
              end else if (cur_pos == len - 8'd3) begin
                save_byte = ver_nxt[15:8];
              end
              crc_nxt = crc_byte(cur_crc, save_byte);
            end
            pos_nxt = cur_pos + 8'd1;
          end
          res.data_out     = save_byte;
          res.primary_addr = base;
          res.mirror_addr  = base + MIRROR_OFFSET;
        end
      end
      default: begin
      end
    endcase

    res.found        = found_nxt;
    res.best_slot    = slot_nxt;
    res.best_copy    = half_nxt;
    res.best_version = ver_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_bytes_r <= RECORD_BYTES_RST;
      slot_count_r   <= SLOT_COUNT_RST;
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      crc_r          <= CRC_INIT;
      pos_r          <= '0;
      vlo_r          <= '0;
      vhi_r          <= '0;
      clo_r          <= '0;
      slot_r         <= ALL_ONES;
      ver_r          <= ALL_ONES;
      loaded_r       <= 1'b0;
      found_r        <= 1'b0;
      half_r         <= 1'b0;
      refused_r      <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_RECORD_BYTES: record_bytes_r <= cfg_if.data;
          CFG_SLOT_COUNT:   slot_count_r   <= cfg_if.data[6:0];
          default: begin
          end
        endcase
      end

      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      if (advance) begin
        crc_r     <= crc_nxt;
        pos_r     <= pos_nxt;
        vlo_r     <= vlo_nxt;
        vhi_r     <= vhi_nxt;
        clo_r     <= clo_nxt;
        slot_r    <= slot_nxt;
        ver_r     <= ver_nxt;
        loaded_r  <= loaded_nxt;
        found_r   <= found_nxt;
        half_r    <= half_nxt;
        refused_r <= refused_nxt;
      end
    end
  end

  // word registers carry no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_word_r <= in_if.word;
    end
    if (advance) begin
      out_word_r <= res;
    end
  end

endmodule
